// ----- design/fcel_pkg.sv -----
`timescale 1ns / 1ps

package fcel_pkg;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;

  localparam logic [2:0] CFG_FAT_KIND           = 3'd0;
  localparam logic [2:0] CFG_VOLUME_MOUNTED     = 3'd1;
  localparam logic [2:0] CFG_TABLE_START_SECTOR = 3'd2;
  localparam logic [2:0] CFG_SECTOR_BYTES       = 3'd3;
  localparam logic [2:0] CFG_CLUSTER_SECTORS    = 3'd4;
  localparam logic [2:0] CFG_DATA_REGION_START  = 3'd5;

  localparam int unsigned DIV_WIDTH  = 32;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = DIV_WIDTH / DIV_STEPS;

  localparam logic [11:0] FAT12_MASK  = 12'h0FFF;
  localparam logic [11:0] FAT12_LIMIT = 12'hFF8;
  localparam logic [15:0] FAT16_LIMIT = 16'hFFF8;
  localparam logic [27:0] FAT32_MASK  = 28'h0FFFFFFF;
  localparam logic [27:0] FAT32_LIMIT = 28'h0FFFFFF8;

  typedef struct packed {
    logic [1:0]  fat_kind;
    logic        volume_mounted;
    logic [7:0]  cluster_sectors;
    logic [31:0] data_region_start;
  } fcel_front_cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] data_sector;
    logic [27:0] next_cluster;
    logic        chain_end;
  } fcel_side_t;

  typedef struct packed {
    logic [31:0] num;
    logic [16:0] rem;
    fcel_side_t  side;
  } fcel_div_t;

endpackage

// ----- design/fat_cluster_entry_lookup_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         tdata: cluster_number, entry_word; tuser: req_type
// m_axis    out        tdata: entry_sector, entry_byte_offset, cluster_data_sector,
//                      next_cluster, chain_end
// cfg       in         cfg_index_i selects the register, cfg_data_i is written
//
// One beat is accepted per cycle while the output is not stalled by m_axis_tready.
// Each beat passes two front stages, then the 32-bit divide for the table sector, split
// over 8 stages of 4 quotient bits each, and then the output register.
// Reset clears the valid bits and loads the register defaults.
// Every stage holds its beat while the next is full, so bubbles close up on a stall.

module fat_cluster_entry_lookup_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // cluster_number [31:0], entry_word [63:32]
  input  logic         s_axis_tuser,   // req_type [0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // entry_sector [31:0], entry_byte_offset [47:32],
                                       // cluster_data_sector [79:48],
                                       // next_cluster [107:80], chain_end [108], zero above
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [1:0]  fat_kind_q;
  logic        volume_mounted_q;
  logic [15:0] table_start_sector_q;
  logic [15:0] sector_bytes_q;
  logic [7:0]  cluster_sectors_q;
  logic [31:0] data_region_start_q;

  fcel_pkg::fcel_front_cfg_t front_cfg;
  logic [16:0]               divisor;

  fcel_pkg::fcel_div_t pipe_data [fcel_pkg::DIV_STAGES+1];
  logic                pipe_valid [fcel_pkg::DIV_STAGES+1];
  logic                pipe_ready [fcel_pkg::DIV_STAGES+1];

  logic                out_valid_q;
  logic [111:0]        out_data_q;
  logic [111:0]        out_data_d;
  fcel_pkg::fcel_div_t last;
  logic [31:0]         sector;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_kind_q           <= fcel_pkg::KIND_FAT12;
      volume_mounted_q     <= 1'b0;
      table_start_sector_q <= 16'd1;
      sector_bytes_q       <= 16'd512;
      cluster_sectors_q    <= 8'd1;
      data_region_start_q  <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fcel_pkg::CFG_FAT_KIND:           fat_kind_q           <= cfg_data_i[1:0];
        fcel_pkg::CFG_VOLUME_MOUNTED:     volume_mounted_q     <= cfg_data_i[0];
        fcel_pkg::CFG_TABLE_START_SECTOR: table_start_sector_q <= cfg_data_i[15:0];
        fcel_pkg::CFG_SECTOR_BYTES:       sector_bytes_q       <= cfg_data_i[15:0];
        fcel_pkg::CFG_CLUSTER_SECTORS:    cluster_sectors_q    <= cfg_data_i[7:0];
        fcel_pkg::CFG_DATA_REGION_START:  data_region_start_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign front_cfg.fat_kind          = fat_kind_q;
  assign front_cfg.volume_mounted    = volume_mounted_q;
  assign front_cfg.cluster_sectors   = cluster_sectors_q;
  assign front_cfg.data_region_start = data_region_start_q;

  // A sector size of zero divides by 65536.
  assign divisor = {sector_bytes_q == 16'd0, sector_bytes_q};

  fcel_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (front_cfg),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .req_type_i       (s_axis_tuser),
    .cluster_number_i (s_axis_tdata[31:0]),
    .entry_word_i     (s_axis_tdata[63:32]),
    .out_valid_o      (pipe_valid[0]),
    .out_ready_i      (pipe_ready[0]),
    .out_o            (pipe_data[0])
  );

  for (genvar k = 0; k < fcel_pkg::DIV_STAGES; k++) begin : g_div
    fcel_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .divisor_i   (divisor),
      .in_valid_i  (pipe_valid[k]),
      .in_ready_o  (pipe_ready[k]),
      .in_i        (pipe_data[k]),
      .out_valid_o (pipe_valid[k+1]),
      .out_ready_i (pipe_ready[k+1]),
      .out_o       (pipe_data[k+1])
    );
  end

  assign pipe_ready[fcel_pkg::DIV_STAGES] = !out_valid_q || m_axis_tready;
  assign last   = pipe_data[fcel_pkg::DIV_STAGES];
  assign sector = {16'd0, table_start_sector_q} + last.num;

  always_comb begin
    out_data_d          = '0;
    out_data_d[79:48]   = last.side.data_sector;
    out_data_d[107:80]  = last.side.next_cluster;
    out_data_d[108]     = last.side.chain_end;
    if (!last.side.req_type) begin
      out_data_d[31:0]  = sector;
      out_data_d[47:32] = last.rem[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_ready[fcel_pkg::DIV_STAGES]) begin
      out_valid_q <= pipe_valid[fcel_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_ready[fcel_pkg::DIV_STAGES] && pipe_valid[fcel_pkg::DIV_STAGES]) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- design/fcel_front.sv -----
`timescale 1ns / 1ps

module fcel_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fcel_pkg::fcel_front_cfg_t cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic [31:0]              cluster_number_i,
  input  logic [31:0]              entry_word_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output fcel_pkg::fcel_div_t      out_o
);

  logic        a_valid_q;
  logic        a_req_q;
  logic [31:0] a_bo_q;
  logic [31:0] a_prod_q;
  logic [27:0] a_next_q;
  logic        a_end_q;
  logic        b_valid_q;
  fcel_pkg::fcel_div_t b_q;

  logic        ready_a;
  logic        ready_b;
  logic [31:0] bo_d;
  logic [31:0] prod_d;
  logic [27:0] val_d;
  logic        over_d;
  logic [27:0] next_d;
  logic        end_d;
  logic [15:0] low16;
  logic [11:0] fat12_val;

  assign ready_b    = !b_valid_q || out_ready_i;
  assign ready_a    = !a_valid_q || ready_b;
  assign in_ready_o = ready_a;

  assign low16     = entry_word_i[15:0];
  assign fat12_val = cluster_number_i[0] ? low16[15:4] : (low16[11:0] & fcel_pkg::FAT12_MASK);
  assign prod_d    = 32'((cluster_number_i - 32'd2) * {24'd0, cfg_i.cluster_sectors});

  always_comb begin
    case (cfg_i.fat_kind)
      fcel_pkg::KIND_FAT12: begin
        bo_d   = cluster_number_i + {1'b0, cluster_number_i[31:1]};
        val_d  = {16'd0, fat12_val};
        over_d = fat12_val >= fcel_pkg::FAT12_LIMIT;
      end
      fcel_pkg::KIND_FAT16: begin
        bo_d   = {cluster_number_i[30:0], 1'b0};
        val_d  = {12'd0, low16};
        over_d = low16 >= fcel_pkg::FAT16_LIMIT;
      end
      default: begin
        bo_d   = {cluster_number_i[29:0], 2'b00};
        val_d  = entry_word_i[27:0] & fcel_pkg::FAT32_MASK;
        over_d = val_d >= fcel_pkg::FAT32_LIMIT;
      end
    endcase
    if (!req_type_i) begin
      next_d = '0;
      end_d  = 1'b0;
    end else if (!cfg_i.volume_mounted || over_d) begin
      next_d = '0;
      end_d  = 1'b1;
    end else begin
      next_d = val_d;
      end_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid_q <= in_valid_i;
      end
      if (ready_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      a_req_q  <= req_type_i;
      a_bo_q   <= bo_d;
      a_prod_q <= prod_d;
      a_next_q <= next_d;
      a_end_q  <= end_d;
    end
    if (ready_b && a_valid_q) begin
      b_q.num              <= a_bo_q;
      b_q.rem              <= '0;
      b_q.side.req_type    <= a_req_q;
      b_q.side.data_sector <= cfg_i.data_region_start + a_prod_q;
      b_q.side.next_cluster <= a_next_q;
      b_q.side.chain_end   <= a_end_q;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule

// ----- design/fcel_div_stage.sv -----
`timescale 1ns / 1ps

module fcel_div_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [16:0]         divisor_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fcel_pkg::fcel_div_t in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fcel_pkg::fcel_div_t out_o
);

  logic                valid_q;
  fcel_pkg::fcel_div_t data_q;
  fcel_pkg::fcel_div_t data_d;
  logic [17:0]         trial;

  assign in_ready_o = !valid_q || out_ready_i;

  // Restoring division, one quotient bit per step.
  always_comb begin
    data_d = in_i;
    trial  = '0;
    for (int i = 0; i < int'(fcel_pkg::DIV_STEPS); i++) begin
      trial      = {data_d.rem, data_d.num[31]};
      data_d.num = {data_d.num[30:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        data_d.rem    = 17'(trial - {1'b0, divisor_i});
        data_d.num[0] = 1'b1;
      end else begin
        data_d.rem = trial[16:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
